// ----- rtl/core/cmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Cube map face select package
// Default widths and face codes shared by the face select / UV unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfs_pkg;

   localparam int COMPONENT_WIDTH = 16;
   localparam int UV_WIDTH        = 16;

   localparam int FACE_WIDTH = 3;

   localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd0;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd1;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd2;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd3;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd4;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/core/cubemap_face_select_uv_unit.sv -----
// ----------------------------------------------------------------------------
// Cube map face select and UV projection unit
// Picks the cube face from the major axis of a direction vector and projects
// the two minor components to unsigned face coordinates.
// ----------------------------------------------------------------------------
// Stages in order: input register, face select, offset add, divider.
// Throughput: one item per cycle unless rsp_tready stalls the output; the
// divider is a chain of UV_WIDTH restoring stages, one quotient bit per stage,
// so every stage is pipelined. Bubbles collapse while the output is stalled.
// Reset clears only the stage valid bits; data registers are not reset.
`default_nettype none

module cubemap_face_select_uv_unit #(
   parameter int COMPONENT_WIDTH = cmfs_pkg::COMPONENT_WIDTH,
   parameter int UV_WIDTH        = cmfs_pkg::UV_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // req_tdata: dir_x, dir_y, dir_z (lowest bits first), zero padded
   input  wire logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // rsp_tdata: coord_u, coord_v (lowest bits first), zero padded
   output logic [((2*UV_WIDTH+7)/8)*8-1:0]            rsp_tdata,
   // rsp_tuser: face[2:0], zero_vector[3]
   output logic [cmfs_pkg::FACE_WIDTH:0]              rsp_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready
);

   localparam int W        = COMPONENT_WIDTH;
   localparam int U        = UV_WIDTH;
   localparam int FW       = cmfs_pkg::FACE_WIDTH;
   localparam int NS       = U + 4;
   localparam int RSP_BITS = ((2*UV_WIDTH+7)/8)*8;

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] z;
   } in_type;

   typedef struct packed {
      logic [FW-1:0]     face;
      logic              zero;
      logic [W-1:0]      m;
      logic signed [W:0] su;
      logic signed [W:0] sv;
   } sel_type;

   typedef struct packed {
      logic [FW-1:0] face;
      logic          zero;
      logic [W:0]    a_u;
      logic [W:0]    a_v;
      logic [W:0]    d;
   } add_type;

   typedef struct packed {
      logic [FW-1:0] face;
      logic          zero;
      logic [W:0]    d;
      logic [W:0]    rem_u;
      logic [W:0]    rem_v;
      logic [U-1:0]  lo_u;
      logic [U-1:0]  lo_v;
      logic [U-1:0]  q_u;
      logic [U-1:0]  q_v;
   } div_type;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   in_type  in_ff,  in_in;
   sel_type sel_ff, sel_in;
   add_type add_ff, add_in;
   div_type div_ff [U+1];
   div_type div_in [U+1];

   // Stage enables: a stage moves when it is empty or its successor moves.
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int i = NS-2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   // Input unpack
   always_comb begin
      in_in.x = req_tdata[W-1:0];
      in_in.y = req_tdata[2*W-1:W];
      in_in.z = req_tdata[3*W-1:2*W];
   end

   // Major axis select and minor component signs
   logic [W-1:0]      ax, ay, az;
   logic signed [W:0] ex, ey, ez;
   logic              sel_x, sel_y;

   always_comb begin
      ax = in_ff.x[W-1] ? (~in_ff.x + 1'b1) : in_ff.x;
      ay = in_ff.y[W-1] ? (~in_ff.y + 1'b1) : in_ff.y;
      az = in_ff.z[W-1] ? (~in_ff.z + 1'b1) : in_ff.z;
      ex = {in_ff.x[W-1], in_ff.x};
      ey = {in_ff.y[W-1], in_ff.y};
      ez = {in_ff.z[W-1], in_ff.z};
      sel_x = (ax >= ay) && (ax >= az);
      sel_y = !sel_x && (ay >= az);
      sel_in.zero = (ax == '0) && (ay == '0) && (az == '0);
      if (sel_x) begin
         sel_in.m    = ax;
         sel_in.face = in_ff.x[W-1] ? cmfs_pkg::FACE_NEG_X : cmfs_pkg::FACE_POS_X;
         sel_in.su   = in_ff.x[W-1] ? -ez : ez;
         sel_in.sv   = -ey;
      end else if (sel_y) begin
         sel_in.m    = ay;
         sel_in.face = in_ff.y[W-1] ? cmfs_pkg::FACE_NEG_Y : cmfs_pkg::FACE_POS_Y;
         sel_in.su   = ex;
         sel_in.sv   = in_ff.y[W-1] ? ez : -ez;
      end else begin
         sel_in.m    = az;
         sel_in.face = in_ff.z[W-1] ? cmfs_pkg::FACE_NEG_Z : cmfs_pkg::FACE_POS_Z;
         sel_in.su   = (ez > 0) ? -ex : ex;
         sel_in.sv   = -ey;
      end
      if (sel_in.zero) begin
         sel_in.face = cmfs_pkg::FACE_NEG_X;
      end
   end

   // Shift minor components into [0, 2m], divisor is 2m
   logic signed [W:0] m_s;

   always_comb begin
      m_s          = {1'b0, sel_ff.m};
      add_in.face  = sel_ff.face;
      add_in.zero  = sel_ff.zero;
      add_in.a_u   = sel_ff.su + m_s;
      add_in.a_v   = sel_ff.sv + m_s;
      add_in.d     = {sel_ff.m, 1'b0};
   end

   logic [W+U:0] n_u, n_v;

   // Restoring divider, one quotient bit per stage
   logic [W+1:0] t_u   [U];
   logic [W+1:0] t_v   [U];
   logic [W+1:0] dif_u [U];
   logic [W+1:0] dif_v [U];
   logic         ge_u  [U];
   logic         ge_v  [U];

   always_comb begin
      // Dividend a * (2^U - 1); top bits seed the remainder (below 2m for a nonzero vector)
      n_u = {add_ff.a_u, {U{1'b0}}} - {{U{1'b0}}, add_ff.a_u};
      n_v = {add_ff.a_v, {U{1'b0}}} - {{U{1'b0}}, add_ff.a_v};
      div_in[0].face  = add_ff.face;
      div_in[0].zero  = add_ff.zero;
      div_in[0].d     = add_ff.d;
      div_in[0].rem_u = n_u[W+U:U];
      div_in[0].rem_v = n_v[W+U:U];
      div_in[0].lo_u  = n_u[U-1:0];
      div_in[0].lo_v  = n_v[U-1:0];
      div_in[0].q_u   = '0;
      div_in[0].q_v   = '0;
      for (int k = 0; k < U; k++) begin
         t_u[k]   = {div_ff[k].rem_u, div_ff[k].lo_u[U-1]};
         t_v[k]   = {div_ff[k].rem_v, div_ff[k].lo_v[U-1]};
         dif_u[k] = t_u[k] - {1'b0, div_ff[k].d};
         dif_v[k] = t_v[k] - {1'b0, div_ff[k].d};
         ge_u[k]  = t_u[k] >= {1'b0, div_ff[k].d};
         ge_v[k]  = t_v[k] >= {1'b0, div_ff[k].d};
         div_in[k+1].face  = div_ff[k].face;
         div_in[k+1].zero  = div_ff[k].zero;
         div_in[k+1].d     = div_ff[k].d;
         div_in[k+1].rem_u = ge_u[k] ? dif_u[k][W:0] : t_u[k][W:0];
         div_in[k+1].rem_v = ge_v[k] ? dif_v[k][W:0] : t_v[k][W:0];
         div_in[k+1].lo_u  = {div_ff[k].lo_u[U-2:0], 1'b0};
         div_in[k+1].lo_v  = {div_ff[k].lo_v[U-2:0], 1'b0};
         div_in[k+1].q_u   = {div_ff[k].q_u[U-2:0], ge_u[k]};
         div_in[k+1].q_v   = {div_ff[k].q_v[U-2:0], ge_v[k]};
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      if (en[0] && req_tvalid) begin
         in_ff <= in_in;
      end
      if (en[1] && valid_ff[0]) begin
         sel_ff <= sel_in;
      end
      if (en[2] && valid_ff[1]) begin
         add_ff <= add_in;
      end
      for (int k = 0; k <= U; k++) begin
         if (en[3+k] && valid_ff[2+k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Output
   logic [U-1:0] coord_u, coord_v;

   assign coord_u    = div_ff[U].zero ? '0 : div_ff[U].q_u;
   assign coord_v    = div_ff[U].zero ? '0 : div_ff[U].q_v;
   assign rsp_tdata  = {{(RSP_BITS-2*U){1'b0}}, coord_v, coord_u};
   assign rsp_tuser  = {div_ff[U].zero, div_ff[U].face};
   assign rsp_tvalid = valid_ff[NS-1];

endmodule

`default_nettype wire

// ----- tb/cubemap_face_select_uv_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Cube map face select / UV unit testbench
// Streams direction vectors into the unit and checks face, coordinates and
// the zero-vector flag of every result against an in-bench projection.
// Directed corner vectors come first, then about a thousand random vectors
// biased toward ties, small magnitudes and zero components. Both sides stall
// in random bursts, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module cubemap_face_select_uv_unit_tb;

   localparam int COMP_W = cmfs_pkg::COMPONENT_WIDTH;
   localparam int UV_W   = cmfs_pkg::UV_WIDTH;
   localparam int FACE_W = cmfs_pkg::FACE_WIDTH;
   localparam int REQ_W  = ((3*COMP_W+7)/8)*8;
   localparam int RSP_W  = ((2*UV_W+7)/8)*8;
   localparam int LATENCY = UV_W + 4;

   localparam int RANDOM_DIRS      = 1000;
   localparam int NO_IDLE_FROM     = 850;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
   } cube_dir_type;

   typedef struct {
      logic [FACE_W-1:0] face;
      logic [UV_W-1:0]   u;
      logic [UV_W-1:0]   v;
      logic              zero;
   } face_uv_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [FACE_W:0]  rsp_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;

   cube_dir_type dir_pending[$];
   face_uv_type  face_uv_due[$];
   cube_dir_type dir_on_bus;

   int   dirs_queued    = 0;
   int   faces_checked  = 0;
   int   mismatch_count = 0;
   logic no_idle        = 1'b0;

   // driver idling state
   int   send_hold = 0;
   int   tx_cycle  = 0;
   logic tx_calm   = 1'b0;

   // receiver idling state
   int   rsp_hold       = 0;
   int   rx_cycle       = 0;
   logic rx_calm        = 1'b0;
   logic long_hold_done = 1'b0;

   cubemap_face_select_uv_unit #(
      .COMPONENT_WIDTH(COMP_W),
      .UV_WIDTH       (UV_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // floor((s + m) * (2^UV_W - 1) / 2m) on the two minor components
   function automatic face_uv_type project_face_uv(input cube_dir_type d);
      longint      x, y, z, ax, ay, az, m, su, sv, uv_max;
      face_uv_type r;
      x = d.x;
      y = d.y;
      z = d.z;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      uv_max = (longint'(1) << UV_W) - 1;
      r.face = '0;
      r.u    = '0;
      r.v    = '0;
      r.zero = 1'b0;
      if (ax == 0 && ay == 0 && az == 0) begin
         r.zero = 1'b1;
         return r;
      end
      if (ax >= ay && ax >= az) begin
         m      = ax;
         r.face = (x < 0) ? cmfs_pkg::FACE_NEG_X : cmfs_pkg::FACE_POS_X;
         su     = (x < 0) ? -z : z;
         sv     = -y;
      end else if (ay >= az) begin
         m      = ay;
         r.face = (y < 0) ? cmfs_pkg::FACE_NEG_Y : cmfs_pkg::FACE_POS_Y;
         su     = x;
         sv     = (y < 0) ? z : -z;
      end else begin
         m      = az;
         r.face = (z < 0) ? cmfs_pkg::FACE_NEG_Z : cmfs_pkg::FACE_POS_Z;
         su     = (z > 0) ? -x : x;
         sv     = -y;
      end
      r.u = UV_W'(((su + m) * uv_max) / (2 * m));
      r.v = UV_W'(((sv + m) * uv_max) / (2 * m));
      return r;
   endfunction

   function automatic logic [REQ_W-1:0] pack_dir(input cube_dir_type d);
      logic [REQ_W-1:0] w;
      w = '0;
      w[COMP_W-1:0]          = d.x;
      w[2*COMP_W-1 -: COMP_W] = d.y;
      w[3*COMP_W-1 -: COMP_W] = d.z;
      return w;
   endfunction

   // full-range value, or a shifted-down one for small magnitudes of either sign
   function automatic logic signed [COMP_W-1:0] random_component();
      logic signed [COMP_W-1:0] c;
      c = COMP_W'($urandom());
      if ($urandom_range(0, 2) == 0)
         c = c >>> $urandom_range(4, COMP_W-1);
      return c;
   endfunction

   function automatic cube_dir_type random_dir();
      cube_dir_type d;
      int unsigned  shape;
      d.x = random_component();
      d.y = random_component();
      d.z = random_component();
      shape = $urandom_range(0, 99);
      if (shape < 3) begin
         d.x = '0;
         d.y = '0;
         d.z = '0;
      end else if (shape < 12) begin
         d.y = $urandom_range(0, 1) ? d.x : -d.x;
      end else if (shape < 20) begin
         d.z = $urandom_range(0, 1) ? d.y : -d.y;
      end else if (shape < 26) begin
         d.z = $urandom_range(0, 1) ? d.x : -d.x;
      end else if (shape < 30) begin
         d.y = $urandom_range(0, 1) ? d.x : -d.x;
         d.z = $urandom_range(0, 1) ? d.x : -d.x;
      end else if (shape < 40) begin
         case ($urandom_range(0, 2))
            0: d.x = '0;
            1: d.y = '0;
            default: d.z = '0;
         endcase
      end
      return d;
   endfunction

   task automatic queue_dir(input int x, input int y, input int z);
      cube_dir_type d;
      d.x = COMP_W'(x);
      d.y = COMP_W'(y);
      d.z = COMP_W'(z);
      dir_pending.push_back(d);
      dirs_queued++;
   endtask

   task automatic wait_all_faces();
      while (faces_checked < dirs_queued)
         @(posedge clock);
   endtask

   // driver: holds an offered vector until its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_hold  <= 0;
      end else begin
         tx_cycle <= tx_cycle + 1;
         if (tx_cycle % 256 == 0)
            tx_calm <= ($urandom_range(0, 3) == 0);
         if (req_tvalid && req_tready)
            face_uv_due.push_back(project_face_uv(dir_on_bus));
         if (req_tvalid && !req_tready) begin
            // keep offering the same vector
         end else if (send_hold != 0) begin
            send_hold  <= send_hold - 1;
            req_tvalid <= 1'b0;
         end else if (!no_idle && !tx_calm && $urandom_range(0, 9) == 0) begin
            send_hold  <= $urandom_range(0, 18);
            req_tvalid <= 1'b0;
         end else if (dir_pending.size() != 0) begin
            dir_on_bus = dir_pending.pop_front();
            req_tdata  <= pack_dir(dir_on_bus);
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 200 == 0)
            rx_calm <= ($urandom_range(0, 3) == 0);
         if (!long_hold_done && faces_checked >= LONG_HOLD_AT) begin
            long_hold_done <= 1'b1;
            rsp_hold       <= LONG_HOLD_CYCLES - 1;
            rsp_tready     <= 1'b0;
         end else if (rsp_hold != 0) begin
            rsp_hold   <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else if (!no_idle && !rx_calm && $urandom_range(0, 9) == 0) begin
            rsp_hold   <= $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: every result transfer against the oldest expected one
   always @(posedge clock) begin
      face_uv_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         faces_checked <= faces_checked + 1;
         if (face_uv_due.size() == 0) begin
            $error("result transfer with no vector outstanding");
            mismatch_count++;
         end else begin
            want = face_uv_due.pop_front();
            if (rsp_tuser[FACE_W-1:0] !== want.face) begin
               $error("face: expected %0d, got %0d", want.face, rsp_tuser[FACE_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[UV_W-1:0] !== want.u) begin
               $error("coord_u: expected %0d, got %0d", want.u, rsp_tdata[UV_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[2*UV_W-1 -: UV_W] !== want.v) begin
               $error("coord_v: expected %0d, got %0d", want.v,
                      rsp_tdata[2*UV_W-1 -: UV_W]);
               mismatch_count++;
            end
            if (rsp_tuser[FACE_W] !== want.zero) begin
               $error("zero_vector: expected %0d, got %0d", want.zero, rsp_tuser[FACE_W]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero vector, one per face, most negative components
      queue_dir(0, 0, 0);
      queue_dir(32767, 0, 0);
      queue_dir(-32767, 0, 0);
      queue_dir(0, 32767, 0);
      queue_dir(0, -32767, 0);
      queue_dir(0, 0, 32767);
      queue_dir(0, 0, -32767);
      queue_dir(-32768, 0, 0);
      queue_dir(0, -32768, 0);
      queue_dir(0, 0, -32768);
      queue_dir(-32768, 32767, -32767);
      // ties: X wins over Y and Z, Y wins over Z
      queue_dir(-32768, -32768, -32768);
      queue_dir(32767, 32767, 32767);
      queue_dir(100, -100, 5);
      queue_dir(3, -200, 200);
      queue_dir(-7, 7, -7);
      queue_dir(0, 1, -1);
      queue_dir(0, -1, 1);
      // minor components at +m and -m
      queue_dir(1000, -1000, 1000);
      queue_dir(1000, 1000, -1000);
      queue_dir(-1000, 1000, 1000);
      queue_dir(1, 0, 0);
      queue_dir(5, -3, -9);
      queue_dir(5, -3, 9);
      queue_dir(-1, 2, 3);
      wait_all_faces();

      for (int i = 0; i < RANDOM_DIRS; i++) begin
         while (dir_pending.size() >= 16)
            @(posedge clock);
         if (i == RANDOM_DIRS / 2)
            wait_all_faces();
         if (i == NO_IDLE_FROM)
            no_idle <= 1'b1;
         dir_pending.push_back(random_dir());
         dirs_queued++;
      end

      wait_all_faces();
      repeat (LATENCY + 8) @(posedge clock);
      if (face_uv_due.size() != 0) begin
         $error("%0d expected results never arrived", face_uv_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("cubemap_face_select_uv_unit_tb: done, clean");
      else
         $display("cubemap_face_select_uv_unit_tb: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("cubemap_face_select_uv_unit_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
